>>> rtl/hangul_syllable_composer_macros.svh
// Assertion macros for the Hangul syllable composer.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef HANGUL_SYLLABLE_COMPOSER_MACROS_SVH
`define HANGUL_SYLLABLE_COMPOSER_MACROS_SVH

`ifndef SYNTHESIS
// a implies b in the same cycle
`define HSC_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hsc assertion failed");
// a implies b in the next cycle
`define HSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hsc assertion failed");
`else
`define HSC_ASSERT_IMPL(label, clk, rst_n, a, b)
`define HSC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> rtl/hsc_pkg.sv
// Shared types, constants and jamo lookup functions for the syllable composer.
// Used by hsc_step, hangul_syllable_composer and tb_top; no dependencies.
package hsc_pkg;

    localparam logic [15:0] SylBase    = 16'hAC00;
    localparam logic [15:0] VowelFirst = 16'h314F;
    localparam logic [15:0] JamoNone   = 16'h0000;
    localparam int          NumMedial  = 21;
    localparam int          NumFinal   = 28;
    localparam logic [1:0]  CountOne   = 2'd1;
    localparam logic [1:0]  CountTwo   = 2'd2;

    typedef struct packed {
        logic [15:0] ini;
        logic [15:0] med;
        logic [15:0] fin;
        logic        comp;
    } state_t;

    typedef struct packed {
        logic        rep;
        logic [1:0]  cnt;
        logic [15:0] first;
        logic [15:0] second;
    } result_t;

    // {found, index}
    function automatic logic [5:0] initial_index(logic [15:0] code);
        logic [5:0] r;
        unique case (code)
            16'h3131: r = {1'b1, 5'd0};
            16'h3132: r = {1'b1, 5'd1};
            16'h3134: r = {1'b1, 5'd2};
            16'h3137: r = {1'b1, 5'd3};
            16'h3138: r = {1'b1, 5'd4};
            16'h3139: r = {1'b1, 5'd5};
            16'h3141: r = {1'b1, 5'd6};
            16'h3142: r = {1'b1, 5'd7};
            16'h3143: r = {1'b1, 5'd8};
            16'h3145: r = {1'b1, 5'd9};
            16'h3146: r = {1'b1, 5'd10};
            16'h3147: r = {1'b1, 5'd11};
            16'h3148: r = {1'b1, 5'd12};
            16'h3149: r = {1'b1, 5'd13};
            16'h314A: r = {1'b1, 5'd14};
            16'h314B: r = {1'b1, 5'd15};
            16'h314C: r = {1'b1, 5'd16};
            16'h314D: r = {1'b1, 5'd17};
            16'h314E: r = {1'b1, 5'd18};
            default:  r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] medial_index(logic [15:0] code);
        logic [15:0] diff;
        diff = code - VowelFirst;
        return {(diff < 16'(NumMedial)), diff[4:0]};
    endfunction

    function automatic logic [5:0] final_index(logic [15:0] code);
        logic [5:0] r;
        unique case (code)
            JamoNone: r = {1'b1, 5'd0};
            16'h3131: r = {1'b1, 5'd1};
            16'h3132: r = {1'b1, 5'd2};
            16'h3133: r = {1'b1, 5'd3};
            16'h3134: r = {1'b1, 5'd4};
            16'h3135: r = {1'b1, 5'd5};
            16'h3136: r = {1'b1, 5'd6};
            16'h3137: r = {1'b1, 5'd7};
            16'h3139: r = {1'b1, 5'd8};
            16'h313A: r = {1'b1, 5'd9};
            16'h313B: r = {1'b1, 5'd10};
            16'h313C: r = {1'b1, 5'd11};
            16'h313D: r = {1'b1, 5'd12};
            16'h313E: r = {1'b1, 5'd13};
            16'h313F: r = {1'b1, 5'd14};
            16'h3140: r = {1'b1, 5'd15};
            16'h3141: r = {1'b1, 5'd16};
            16'h3142: r = {1'b1, 5'd17};
            16'h3144: r = {1'b1, 5'd18};
            16'h3145: r = {1'b1, 5'd19};
            16'h3146: r = {1'b1, 5'd20};
            16'h3147: r = {1'b1, 5'd21};
            16'h3148: r = {1'b1, 5'd22};
            16'h314A: r = {1'b1, 5'd23};
            16'h314B: r = {1'b1, 5'd24};
            16'h314C: r = {1'b1, 5'd25};
            16'h314D: r = {1'b1, 5'd26};
            16'h314E: r = {1'b1, 5'd27};
            default:  r = 6'd0;
        endcase
        return r;
    endfunction

    // Syllable code point, or zero when any part is not a valid jamo.
    function automatic logic [15:0] compose_syl(logic [15:0] ini, logic [15:0] med,
                                                logic [15:0] fin);
        logic [5:0]  a;
        logic [5:0]  b;
        logic [5:0]  c;
        logic [8:0]  ab;
        logic [13:0] off;
        a   = initial_index(ini);
        b   = medial_index(med);
        c   = final_index(fin);
        ab  = 9'(a[4:0]) * 9'(NumMedial) + 9'(b[4:0]);
        off = 14'(ab) * 14'(NumFinal) + 14'(c[4:0]);
        return (a[5] && b[5] && c[5]) ? SylBase + 16'(off) : JamoNone;
    endfunction

    // Double final made of final fin followed by consonant c, or zero.
    function automatic logic [15:0] dbl_join(logic [15:0] fin, logic [15:0] c);
        logic [15:0] r;
        unique case ({fin, c})
            {16'h3131, 16'h3145}: r = 16'h3133;
            {16'h3134, 16'h3148}: r = 16'h3135;
            {16'h3134, 16'h314E}: r = 16'h3136;
            {16'h3139, 16'h3131}: r = 16'h313A;
            {16'h3139, 16'h3141}: r = 16'h313B;
            {16'h3139, 16'h3142}: r = 16'h313C;
            {16'h3139, 16'h3145}: r = 16'h313D;
            {16'h3139, 16'h314C}: r = 16'h313E;
            {16'h3139, 16'h314D}: r = 16'h313F;
            {16'h3139, 16'h314E}: r = 16'h3140;
            {16'h3142, 16'h3145}: r = 16'h3144;
            default:              r = JamoNone;
        endcase
        return r;
    endfunction

    // {part kept by the old syllable, part moved to the new one}
    function automatic logic [31:0] dbl_split(logic [15:0] fin);
        logic [31:0] r;
        unique case (fin)
            16'h3133: r = {16'h3131, 16'h3145};
            16'h3135: r = {16'h3134, 16'h3148};
            16'h3136: r = {16'h3134, 16'h314E};
            16'h313A: r = {16'h3139, 16'h3131};
            16'h313B: r = {16'h3139, 16'h3141};
            16'h313C: r = {16'h3139, 16'h3142};
            16'h313D: r = {16'h3139, 16'h3145};
            16'h313E: r = {16'h3139, 16'h314C};
            16'h313F: r = {16'h3139, 16'h314D};
            16'h3140: r = {16'h3139, 16'h314E};
            16'h3144: r = {16'h3142, 16'h3145};
            default:  r = {JamoNone, fin};
        endcase
        return r;
    endfunction

    function automatic logic [15:0] cx_vowel(logic [15:0] med, logic [15:0] c);
        logic [15:0] r;
        unique case ({med, c})
            {16'h3157, 16'h314F}: r = 16'h3158;
            {16'h3157, 16'h3150}: r = 16'h3159;
            {16'h3157, 16'h3163}: r = 16'h315A;
            {16'h315C, 16'h3153}: r = 16'h315D;
            {16'h315C, 16'h3154}: r = 16'h315E;
            {16'h315C, 16'h3163}: r = 16'h315F;
            {16'h3161, 16'h3163}: r = 16'h3162;
            default:              r = JamoNone;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/hsc_step.sv
// Composition automaton step: next syllable state and result for one code point.
// Purely combinational; depends on hsc_pkg.
module hsc_step
(
    input  hsc_pkg::state_t  cur,
    input  logic [15:0]      char_code,
    output hsc_pkg::state_t  nxt,
    output hsc_pkg::result_t res
);

    logic [5:0]  c_ini;
    logic [5:0]  c_med;
    logic [15:0] syl_fin;
    logic [15:0] dbl;
    logic [15:0] syl_dbl;
    logic [15:0] syl_med;
    logic [31:0] split;
    logic [15:0] syl_keep;
    logic [15:0] syl_move;
    logic [15:0] cv;
    logic [15:0] syl_cv;
    hsc_pkg::state_t start_st;

    assign c_ini    = hsc_pkg::initial_index(char_code);
    assign c_med    = hsc_pkg::medial_index(char_code);
    assign syl_fin  = hsc_pkg::compose_syl(cur.ini, cur.med, char_code);
    assign dbl      = hsc_pkg::dbl_join(cur.fin, char_code);
    assign syl_dbl  = (dbl != hsc_pkg::JamoNone)
                    ? hsc_pkg::compose_syl(cur.ini, cur.med, dbl) : hsc_pkg::JamoNone;
    assign syl_med  = hsc_pkg::compose_syl(cur.ini, char_code, hsc_pkg::JamoNone);
    assign split    = hsc_pkg::dbl_split(cur.fin);
    assign syl_keep = hsc_pkg::compose_syl(cur.ini, cur.med, split[31:16]);
    assign syl_move = hsc_pkg::compose_syl(split[15:0], char_code, hsc_pkg::JamoNone);
    assign cv       = hsc_pkg::cx_vowel(cur.med, char_code);
    assign syl_cv   = (cv != hsc_pkg::JamoNone)
                    ? hsc_pkg::compose_syl(cur.ini, cv, hsc_pkg::JamoNone) : hsc_pkg::JamoNone;

    assign start_st = '{ini: char_code, med: hsc_pkg::JamoNone, fin: hsc_pkg::JamoNone,
                        comp: 1'b1};

    always_comb
    begin
        // default: emit the code point alone and end composition
        nxt        = '0;
        res.rep    = 1'b0;
        res.cnt    = hsc_pkg::CountOne;
        res.first  = char_code;
        res.second = hsc_pkg::JamoNone;

        if (c_ini[5])
        begin
            nxt = start_st;
            if (cur.comp && cur.med != hsc_pkg::JamoNone)
            begin
                if (cur.fin == hsc_pkg::JamoNone)
                begin
                    if (syl_fin != hsc_pkg::JamoNone)
                    begin
                        nxt       = cur;
                        nxt.fin   = char_code;
                        res.rep   = 1'b1;
                        res.first = syl_fin;
                    end
                end
                else if (syl_dbl != hsc_pkg::JamoNone)
                begin
                    nxt       = cur;
                    nxt.fin   = dbl;
                    res.rep   = 1'b1;
                    res.first = syl_dbl;
                end
            end
        end
        else if (c_med[5] && cur.comp && cur.ini != hsc_pkg::JamoNone)
        begin
            if (cur.med == hsc_pkg::JamoNone)
            begin
                if (syl_med != hsc_pkg::JamoNone)
                begin
                    nxt       = cur;
                    nxt.med   = char_code;
                    res.rep   = 1'b1;
                    res.first = syl_med;
                end
            end
            else if (cur.fin != hsc_pkg::JamoNone)
            begin
                // split the final: the moved part starts the next syllable
                nxt        = '{ini: split[15:0], med: char_code, fin: hsc_pkg::JamoNone,
                               comp: 1'b1};
                res.rep    = 1'b1;
                res.cnt    = hsc_pkg::CountTwo;
                res.first  = syl_keep;
                res.second = syl_move;
            end
            else if (syl_cv != hsc_pkg::JamoNone)
            begin
                nxt       = cur;
                nxt.med   = cv;
                res.rep   = 1'b1;
                res.first = syl_cv;
            end
        end
    end

endmodule

>>> rtl/hangul_syllable_composer.sv
// Hangul syllable composer: one Unicode code point in, one result beat out.
//
// Input stream: s_axis_tdata[15:0] is the typed code point (compatibility jamo
// or any other character). Output stream: m_axis_tuser[0] is replace_previous,
// m_axis_tdata carries char_count, first_char and second_char.
// Every input beat gives exactly one output beat, in order.
//
// Path: an accepted beat is registered in the input register, run through the jamo
// tables and the syllable arithmetic (two constant multiplies), and loaded into
// the output register once that register is free or draining, raising m_axis_tvalid.
// Throughput is one beat per cycle while m_axis_tready stays high: the syllable
// state updates in the same cycle the output register loads.
// Stall: while m_axis_tready is low the output beat holds; one further input
// beat is taken into the input register and then s_axis_tready drops.
// Reset clears the syllable state (no composition in progress) and empties
// both registers. Depends on hsc_pkg, hsc_step and the macros header.
`include "hangul_syllable_composer_macros.svh"

module hangul_syllable_composer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] char_count, [17:2] first_char,
                                        // [33:18] second_char, [39:34] zero
    output logic [0:0]  m_axis_tuser    // [0] replace_previous
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [15:0]      char_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    hsc_pkg::result_t out_reg;
    hsc_pkg::state_t  state_reg;
    hsc_pkg::state_t  state_next;
    hsc_pkg::result_t step_res;
    logic             in_take;
    logic             advance;

    hsc_step u_step
    (
        .cur       (state_reg),
        .char_code (char_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    // advance the held beat when the output register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            char_reg <= s_axis_tdata;
        if (advance)
            out_reg <= step_res;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_reg.rep;
    assign m_axis_tdata    = {6'd0, out_reg.second, out_reg.first, out_reg.cnt};

    `HSC_ASSERT_IMPL(a_idle_clear, clk, rst_n, !state_reg.comp, state_reg.ini == hsc_pkg::JamoNone && state_reg.med == hsc_pkg::JamoNone && state_reg.fin == hsc_pkg::JamoNone)
    `HSC_ASSERT_IMPL(a_comp_has_ini, clk, rst_n, state_reg.comp, state_reg.ini != hsc_pkg::JamoNone)
    `HSC_ASSERT_IMPL(a_fin_needs_med, clk, rst_n, state_reg.fin != hsc_pkg::JamoNone, state_reg.med != hsc_pkg::JamoNone)
    `HSC_ASSERT_IMPL(a_two_replaces, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] == hsc_pkg::CountTwo, m_axis_tuser[0])
    `HSC_ASSERT_NEXT(a_adv_loads_out, clk, rst_n, advance, m_axis_tvalid)

endmodule

>>> verif/tb_top.sv
// Self-checking bench for hangul_syllable_composer: drives code points in bursts and
// checks every output beat against a built-in model of the two-set composition automaton
// or, for typed script rows, a result read off by hand. Depends on hsc_pkg and the RTL.
module tb_top;

    localparam int NumOnset     = 19;
    localparam int NumRandom    = 1350;
    localparam int DrainAtCount = 700;

    // Jamo lists, written left to right in table order
    localparam logic [NumOnset*16-1:0] ONSET_LIST = {
        16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
        16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
        16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
    };
    localparam logic [27*16-1:0] CODA_LIST = {
        16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136, 16'h3137,
        16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E, 16'h313F,
        16'h3140, 16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146, 16'h3147,
        16'h3148, 16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
    };
    // {double final, part kept, part moved}
    localparam logic [11*48-1:0] CLUSTER_LIST = {
        16'h3133, 16'h3131, 16'h3145,  16'h3135, 16'h3134, 16'h3148,
        16'h3136, 16'h3134, 16'h314E,  16'h313A, 16'h3139, 16'h3131,
        16'h313B, 16'h3139, 16'h3141,  16'h313C, 16'h3139, 16'h3142,
        16'h313D, 16'h3139, 16'h3145,  16'h313E, 16'h3139, 16'h314C,
        16'h313F, 16'h3139, 16'h314D,  16'h3140, 16'h3139, 16'h314E,
        16'h3144, 16'h3142, 16'h3145
    };
    // {first vowel, second vowel, merged vowel}
    localparam logic [7*48-1:0] DIPHTHONG_LIST = {
        16'h3157, 16'h314F, 16'h3158,  16'h3157, 16'h3150, 16'h3159,
        16'h3157, 16'h3163, 16'h315A,  16'h315C, 16'h3153, 16'h315D,
        16'h315C, 16'h3154, 16'h315E,  16'h315C, 16'h3163, 16'h315F,
        16'h3161, 16'h3163, 16'h3162
    };

    typedef struct packed {
        logic        rep;
        logic [1:0]  cnt;
        logic [15:0] first;
        logic [15:0] second;
    } emit_t;

    typedef struct packed {
        logic [15:0] code;
        logic        typed;
        emit_t       want;
    } keystroke_row_t;

    localparam emit_t FROM_MODEL = '0;
    localparam int    NumScript  = 25;

    // Directed keystrokes; rows marked typed carry the result read off by hand
    keystroke_row_t script [NumScript] = '{
        '{16'h0000, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h0000, 16'h0000}},
        '{16'hFFFF, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'hFFFF, 16'h0000}},
        '{16'h3131, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3131, 16'h0000}},
        '{16'h314F, 1'b1, '{1'b1, hsc_pkg::CountOne, 16'hAC00, 16'h0000}},
        '{16'h3139, 1'b0, FROM_MODEL},
        '{16'h3131, 1'b0, FROM_MODEL},
        '{16'h314F, 1'b1, '{1'b1, hsc_pkg::CountTwo, 16'hAC08, 16'hAC00}},
        '{16'h3143, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3143, 16'h0000}},
        '{16'h3157, 1'b0, FROM_MODEL},
        '{16'h314F, 1'b0, FROM_MODEL},
        '{16'h3163, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3163, 16'h0000}},
        '{16'h3163, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3163, 16'h0000}},
        '{16'h314E, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h314E, 16'h0000}},
        '{16'h3161, 1'b0, FROM_MODEL},
        '{16'h3163, 1'b0, FROM_MODEL},
        '{16'h314E, 1'b0, FROM_MODEL},
        '{16'h3145, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3145, 16'h0000}},
        '{16'h3163, 1'b0, FROM_MODEL},
        '{16'h3142, 1'b0, FROM_MODEL},
        '{16'h3145, 1'b0, FROM_MODEL},
        '{16'h3131, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3131, 16'h0000}},
        '{16'h3132, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3132, 16'h0000}},
        '{16'h3163, 1'b0, FROM_MODEL},
        '{16'h3164, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3164, 16'h0000}},
        '{16'h3130, 1'b1, '{1'b0, hsc_pkg::CountOne, 16'h3130, 16'h0000}}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Syllable under composition, as the model sees it
    logic [15:0] cur_ini;
    logic [15:0] cur_med;
    logic [15:0] cur_fin;
    logic        cur_comp;

    emit_t pending_emits[$];
    emit_t arrived;
    int    mismatch_count = 0;
    int    stall_mode     = 0;
    int    stall_left     = 0;

    hangul_syllable_composer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [15:0] onset_at(int i);
        return ONSET_LIST[(NumOnset-1-i)*16 +: 16];
    endfunction

    function automatic int onset_idx(logic [15:0] code);
        for (int i = 0; i < NumOnset; i++)
        begin
            if (onset_at(i) == code)
                return i;
        end
        return -1;
    endfunction

    function automatic int vowel_idx(logic [15:0] code);
        if (code >= hsc_pkg::VowelFirst && code < hsc_pkg::VowelFirst + hsc_pkg::NumMedial)
            return int'(code - hsc_pkg::VowelFirst);
        return -1;
    endfunction

    function automatic int coda_idx(logic [15:0] code);
        if (code == hsc_pkg::JamoNone)
            return 0;
        for (int i = 1; i < hsc_pkg::NumFinal; i++)
        begin
            if (CODA_LIST[(hsc_pkg::NumFinal-1-i)*16 +: 16] == code)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [15:0] cluster_field(int i, int k);
        return CLUSTER_LIST[(10-i)*48 + (2-k)*16 +: 16];
    endfunction

    function automatic logic [15:0] diphthong_field(int i, int k);
        return DIPHTHONG_LIST[(6-i)*48 + (2-k)*16 +: 16];
    endfunction

    // Syllable code point, or none when any part is not a valid jamo
    function automatic logic [15:0] jamo_syllable(logic [15:0] ini, logic [15:0] med,
                                                  logic [15:0] fin);
        int a;
        int b;
        int c;
        a = onset_idx(ini);
        b = vowel_idx(med);
        c = coda_idx(fin);
        if (a < 0 || b < 0 || c < 0)
            return hsc_pkg::JamoNone;
        return 16'(int'(hsc_pkg::SylBase)
                   + (a * hsc_pkg::NumMedial + b) * hsc_pkg::NumFinal + c);
    endfunction

    function automatic void open_syllable(logic [15:0] code);
        cur_ini  = code;
        cur_med  = hsc_pkg::JamoNone;
        cur_fin  = hsc_pkg::JamoNone;
        cur_comp = 1'b1;
    endfunction

    function automatic void end_composition();
        cur_ini  = hsc_pkg::JamoNone;
        cur_med  = hsc_pkg::JamoNone;
        cur_fin  = hsc_pkg::JamoNone;
        cur_comp = 1'b0;
    endfunction

    // Advance the composition by one keystroke and return the beat it produces
    function automatic emit_t compose_keystroke(logic [15:0] code);
        emit_t       e;
        logic [15:0] syl;
        logic [15:0] joined;
        logic [15:0] keep;
        logic [15:0] move;
        e = '{1'b0, hsc_pkg::CountOne, code, hsc_pkg::JamoNone};
        if (onset_idx(code) >= 0)
        begin
            if (!cur_comp || cur_med == hsc_pkg::JamoNone)
                open_syllable(code);
            else
            begin
                if (cur_fin == hsc_pkg::JamoNone)
                    joined = code;
                else
                begin
                    joined = hsc_pkg::JamoNone;
                    for (int i = 0; i < 11; i++)
                    begin
                        if (cluster_field(i, 1) == cur_fin && cluster_field(i, 2) == code)
                            joined = cluster_field(i, 0);
                    end
                end
                syl = (joined != hsc_pkg::JamoNone)
                    ? jamo_syllable(cur_ini, cur_med, joined) : hsc_pkg::JamoNone;
                if (syl != hsc_pkg::JamoNone)
                begin
                    cur_fin = joined;
                    e.rep   = 1'b1;
                    e.first = syl;
                end
                else
                    open_syllable(code);
            end
        end
        else if (vowel_idx(code) >= 0)
        begin
            if (!cur_comp || cur_ini == hsc_pkg::JamoNone)
                end_composition();
            else if (cur_fin != hsc_pkg::JamoNone)
            begin
                // split the final: a cluster leaves its first part behind
                keep = hsc_pkg::JamoNone;
                move = cur_fin;
                for (int i = 0; i < 11; i++)
                begin
                    if (cluster_field(i, 0) == cur_fin)
                    begin
                        keep = cluster_field(i, 1);
                        move = cluster_field(i, 2);
                    end
                end
                e.rep    = 1'b1;
                e.cnt    = hsc_pkg::CountTwo;
                e.first  = jamo_syllable(cur_ini, cur_med, keep);
                e.second = jamo_syllable(move, code, hsc_pkg::JamoNone);
                cur_ini  = move;
                cur_med  = code;
                cur_fin  = hsc_pkg::JamoNone;
            end
            else
            begin
                if (cur_med == hsc_pkg::JamoNone)
                    joined = code;
                else
                begin
                    joined = hsc_pkg::JamoNone;
                    for (int i = 0; i < 7; i++)
                    begin
                        if (diphthong_field(i, 0) == cur_med && diphthong_field(i, 1) == code)
                            joined = diphthong_field(i, 2);
                    end
                end
                syl = (joined != hsc_pkg::JamoNone)
                    ? jamo_syllable(cur_ini, joined, hsc_pkg::JamoNone) : hsc_pkg::JamoNone;
                if (syl != hsc_pkg::JamoNone)
                begin
                    cur_med = joined;
                    e.rep   = 1'b1;
                    e.first = syl;
                end
                else
                    end_composition();
            end
        end
        else
            end_composition();
        return e;
    endfunction

    // Mostly jamo so that syllables, clusters and splits keep happening
    function automatic logic [15:0] random_keystroke();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return onset_at($urandom_range(0, NumOnset-1));
        if (pick < 85)
            return hsc_pkg::VowelFirst + 16'($urandom_range(0, hsc_pkg::NumMedial-1));
        if (pick < 92)
            return 16'h3130 + 16'($urandom_range(0, 16'h34));
        return 16'($urandom);
    endfunction

    task automatic send_keystroke(input logic [15:0] code, input logic typed,
                                  input emit_t typed_want);
        emit_t e;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        e = compose_keystroke(code);
        pending_emits.push_back(typed ? typed_want : e);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_emits.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver: switch at random among stall patterns for m_axis_tready
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
            2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
            default: m_axis_tready <= stall_left[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_emits.size() == 0)
            begin
                $display("%0t: beat with nothing expected, tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                arrived = pending_emits.pop_front();
                check_field("replace_previous", 16'(arrived.rep), 16'(m_axis_tuser[0]));
                check_field("char_count", 16'(arrived.cnt), 16'(m_axis_tdata[1:0]));
                check_field("first_char", arrived.first, m_axis_tdata[17:2]);
                check_field("second_char", arrived.second, m_axis_tdata[33:18]);
                check_field("tdata pad", 16'h0000, 16'(m_axis_tdata[39:34]));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int sent;
        int burst;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0000;
        m_axis_tready = 1'b0;
        end_composition();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumScript; i++)
            send_keystroke(script[i].code, script[i].typed, script[i].want);
        wait_drained();

        sent = 0;
        while (sent < NumRandom)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < NumRandom; i++)
            begin
                send_keystroke(random_keystroke(), 1'b0, FROM_MODEL);
                sent++;
                // hold off once until the composer has emptied
                if (sent == DrainAtCount)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> hangul_syllable_composer.f
+incdir+rtl
rtl/hsc_pkg.sv
rtl/hsc_step.sv
rtl/hangul_syllable_composer.sv
verif/tb_top.sv
